/* src/rba_pkg.sv */
package rba_pkg;

    typedef logic [31:0] t_word;

    // One input transfer: operation code and zone number.
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] zone_id;
    } t_in_item;

    // One result transfer.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] zone;
        logic [31:0] ref_count;
        logic [27:0] free_blocks;
    } t_out_item;

    // Control of the shared adder: enable, invert operand b, carry in.
    typedef struct packed {
        logic en;
        logic inv;
        logic cin;
    } t_alu_ctl;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_ADDREF  = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_NOSPACE  = 3'd1;
    localparam logic [2:0] STAT_OUTSIDE  = 3'd2;
    localparam logic [2:0] STAT_OVERFLOW = 3'd3;
    localparam logic [2:0] STAT_UNDERFLOW = 3'd4;
    localparam logic [2:0] STAT_BITCLR   = 3'd5;

    localparam logic [1:0] CFG_FIRST = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] CFG_LOG   = 2'd2;

    // Position of the lowest clear bit of a map word.
    function automatic logic [4:0] first_zero(input logic [31:0] w);
        logic [4:0] pos;
        pos = '0;
        for (int k = 31; k >= 0; k--) begin
            if (!w[k]) begin
                pos = 5'(k);
            end
        end
        return pos;
    endfunction

endpackage

/* src/refcounted_block_allocator_top.sv */
// Allocate hands out the lowest clear bit of the busy map:
// the busy map RAM is scanned one 32-bit word per cycle on its single read port.
// One item is in work at a time; the next transfer is taken once the result is registered.
// Reset is synchronous and active low; afterwards a clearing pass over every map index
// initialises both RAMs, during which no item is taken (configuration writes still are).
module refcounted_block_allocator_top #(
    parameter int MAP_BITS = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rba_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rba_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_wdata
);

    // The busy map is held as words of 32 bits; any padding bits beyond MAP_BITS
    // are set at initialisation so that the scan never hands them out.
    localparam int IW    = $clog2(MAP_BITS);
    localparam int WORDS = (MAP_BITS + 31) / 32;
    localparam int WAW   = $clog2(WORDS);
    localparam int FCW   = IW + 1;
    localparam logic [IW-1:0]  LAST_IDX  = IW'(MAP_BITS - 1);
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_PICK  = 4'd3;
    localparam logic [3:0] S_ASET  = 4'd4;
    localparam logic [3:0] S_AZONE = 4'd5;
    localparam logic [3:0] S_ALO   = 4'd6;
    localparam logic [3:0] S_AHI   = 4'd7;
    localparam logic [3:0] S_AFIN  = 4'd8;
    localparam logic [3:0] S_RLO   = 4'd9;
    localparam logic [3:0] S_RHI   = 4'd10;
    localparam logic [3:0] S_RMAX  = 4'd11;
    localparam logic [3:0] S_RIDX  = 4'd12;
    localparam logic [3:0] S_RCALC = 4'd13;
    localparam logic [3:0] S_RWB   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic [IW-1:0]      r_clr;

    // Configuration registers.
    rba_pkg::t_word     r_first;
    rba_pkg::t_word     r_zcount;
    logic [3:0]         r_log;

    // Scan control.
    logic [WAW-1:0]     r_ptr;
    logic               r_issue_done;
    logic               r_chk;
    logic [WAW-1:0]     r_chk_addr;

    // Working registers of the current item.
    logic [1:0]         r_op;
    rba_pkg::t_word     r_zone;
    rba_pkg::t_word     r_d;
    logic               r_fail;
    logic [31:0]        r_word;
    logic [WAW-1:0]     r_waddr;
    logic [IW-1:0]      r_idx;
    rba_pkg::t_word     r_count_rd;
    logic [2:0]         r_res_status;
    rba_pkg::t_word     r_res_zone;
    rba_pkg::t_word     r_res_count;
    logic [FCW-1:0]     r_free;

    rba_pkg::t_out_item r_out;
    logic               r_out_valid;

    // RAM ports.
    logic               map_we;
    logic [WAW-1:0]     map_waddr;
    logic [31:0]        map_wdata;
    logic [WAW-1:0]     map_raddr;
    logic [31:0]        map_rdata;
    logic               ref_we;
    logic [IW-1:0]      ref_waddr;
    rba_pkg::t_word     ref_wdata;
    logic [IW-1:0]      ref_raddr;
    rba_pkg::t_word     ref_rdata;

    // Shared adder.
    rba_pkg::t_alu_ctl  alu_ctl;
    rba_pkg::t_word     alu_a;
    rba_pkg::t_word     alu_b;
    rba_pkg::t_word     alu_sum;
    logic               alu_carry;

    logic               in_acc;
    logic               out_load;
    logic [31:0]        clr_word;
    logic               free_inc;
    logic               free_dec;
    logic               res_load;
    logic [2:0]         res_status;
    rba_pkg::t_word     res_zone;
    rba_pkg::t_word     res_count;
    rba_pkg::t_word     new_cnt;
    logic               rmax_fail;
    logic               alo_fail;
    logic [31:0]        free_shift;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign rmax_fail   = r_fail | alu_carry;
    assign alo_fail    = r_fail | alu_carry;
    assign free_shift  = 32'(r_free) << r_log;

    rba_ram #(
        .WIDTH (32),
        .DEPTH (WORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    rba_ram #(
        .WIDTH (32),
        .DEPTH (MAP_BITS)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (ref_wdata),
        .i_raddr (ref_raddr),
        .o_rdata (ref_rdata)
    );

    rba_alu u_alu (
        .i_clk   (i_clk),
        .i_ctl   (alu_ctl),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    // Initial contents of the map word being cleared: index 0 is reserved and any
    // padding beyond the map is marked busy.
    always_comb begin
        for (int b = 0; b < 32; b++) begin
            clr_word[b] = ({1'b0, r_clr[WAW-1:0], 5'(b)} == '0) ||
                          ({1'b0, r_clr[WAW-1:0], 5'(b)} >= FCW'(MAP_BITS));
        end
    end

    // Sequencer: next state, RAM and adder control, and the result of the item.
    always_comb begin
        n_state    = r_state;
        map_we     = 1'b0;
        map_waddr  = r_waddr;
        map_wdata  = r_word;
        map_raddr  = r_ptr;
        ref_we     = 1'b0;
        ref_waddr  = r_idx;
        ref_wdata  = '0;
        ref_raddr  = r_idx;
        alu_ctl    = '0;
        alu_a      = r_d;
        alu_b      = '0;
        free_inc   = 1'b0;
        free_dec   = 1'b0;
        res_load   = 1'b0;
        res_status = rba_pkg::STAT_OK;
        res_zone   = r_zone;
        res_count  = '0;
        new_cnt    = '0;

        unique case (r_state)
            S_CLEAR: begin
                ref_we    = 1'b1;
                ref_waddr = r_clr;
                if (r_clr < IW'(WORDS)) begin
                    map_we    = 1'b1;
                    map_waddr = r_clr[WAW-1:0];
                    map_wdata = clr_word;
                end
                if (r_clr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.operation) inside
                        rba_pkg::OP_ALLOC: begin
                            n_state = S_SCAN;
                        end
                        rba_pkg::OP_RELEASE, rba_pkg::OP_ADDREF: begin
                            // Zone minus first data zone; no carry means below the area.
                            alu_ctl = '{en: 1'b1, inv: 1'b1, cin: 1'b1};
                            alu_a   = i_in_data.zone_id;
                            alu_b   = r_first;
                            n_state = S_RLO;
                        end
                        default: begin
                            res_load   = 1'b1;
                            res_status = rba_pkg::STAT_OK;
                            res_zone   = i_in_data.zone_id;
                            res_count  = '0;
                            n_state    = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                map_raddr = r_ptr;
                if (r_chk) begin
                    if (~map_rdata != '0) begin
                        n_state = S_PICK;
                    end else if (r_chk_addr == LAST_WORD) begin
                        res_load   = 1'b1;
                        res_status = rba_pkg::STAT_NOSPACE;
                        res_zone   = '0;
                        res_count  = '0;
                        n_state    = S_DONE;
                    end
                end
            end
            S_PICK: begin
                n_state = S_ASET;
            end
            S_ASET: begin
                map_we    = 1'b1;
                map_waddr = r_waddr;
                map_wdata = r_word | (32'd1 << r_idx[4:0]);
                ref_we    = 1'b1;
                ref_waddr = r_idx;
                ref_wdata = 32'd1;
                free_dec  = 1'b1;
                alu_ctl   = '{en: 1'b1, inv: 1'b0, cin: 1'b0};
                alu_a     = 32'(r_idx);
                alu_b     = r_first;
                n_state   = S_AZONE;
            end
            S_AZONE: begin
                // Subtract one by adding all ones.
                alu_ctl = '{en: 1'b1, inv: 1'b1, cin: 1'b0};
                alu_a   = alu_sum;
                alu_b   = '0;
                n_state = S_ALO;
            end
            S_ALO: begin
                alu_ctl = '{en: 1'b1, inv: 1'b1, cin: 1'b1};
                alu_a   = alu_sum;
                alu_b   = r_first;
                n_state = S_AHI;
            end
            S_AHI: begin
                alu_ctl = '{en: 1'b1, inv: 1'b1, cin: 1'b1};
                alu_a   = r_zone;
                alu_b   = r_zcount;
                n_state = S_AFIN;
            end
            S_AFIN: begin
                res_load   = 1'b1;
                res_status = alo_fail ? rba_pkg::STAT_OUTSIDE : rba_pkg::STAT_OK;
                res_zone   = alo_fail ? '0 : r_zone;
                res_count  = 32'd1;
                n_state    = S_DONE;
            end
            S_RLO: begin
                alu_ctl = '{en: 1'b1, inv: 1'b1, cin: 1'b1};
                alu_a   = r_zone;
                alu_b   = r_zcount;
                n_state = S_RHI;
            end
            S_RHI: begin
                alu_ctl = '{en: 1'b1, inv: 1'b1, cin: 1'b1};
                alu_a   = r_d;
                alu_b   = 32'(MAP_BITS - 1);
                n_state = S_RMAX;
            end
            S_RMAX: begin
                if (rmax_fail) begin
                    res_load   = 1'b1;
                    res_status = rba_pkg::STAT_OUTSIDE;
                    res_zone   = r_zone;
                    res_count  = '0;
                    n_state    = S_DONE;
                end else begin
                    alu_ctl = '{en: 1'b1, inv: 1'b0, cin: 1'b1};
                    alu_a   = r_d;
                    alu_b   = '0;
                    n_state = S_RIDX;
                end
            end
            S_RIDX: begin
                map_raddr = alu_sum[IW-1:5];
                ref_raddr = alu_sum[IW-1:0];
                n_state   = S_RCALC;
            end
            S_RCALC: begin
                alu_a = ref_rdata;
                alu_b = '0;
                if (r_op == rba_pkg::OP_RELEASE) begin
                    alu_ctl = '{en: 1'b1, inv: 1'b1, cin: 1'b0};
                end else begin
                    alu_ctl = '{en: 1'b1, inv: 1'b0, cin: 1'b1};
                end
                n_state = S_RWB;
            end
            S_RWB: begin
                res_load  = 1'b1;
                res_zone  = r_zone;
                ref_we    = 1'b1;
                ref_waddr = r_idx;
                if (r_op == rba_pkg::OP_RELEASE) begin
                    if (r_count_rd == '0) begin
                        new_cnt    = '0;
                        res_status = rba_pkg::STAT_UNDERFLOW;
                    end else begin
                        new_cnt    = alu_sum;
                        res_status = rba_pkg::STAT_OK;
                    end
                    if (new_cnt == '0) begin
                        if (r_word[r_idx[4:0]]) begin
                            map_we    = 1'b1;
                            map_waddr = r_idx[IW-1:5];
                            map_wdata = r_word & ~(32'd1 << r_idx[4:0]);
                            free_inc  = 1'b1;
                        end else if (r_count_rd != '0) begin
                            res_status = rba_pkg::STAT_BITCLR;
                        end
                    end
                end else begin
                    if (&r_count_rd) begin
                        new_cnt    = r_count_rd;
                        res_status = rba_pkg::STAT_OVERFLOW;
                    end else begin
                        new_cnt    = alu_sum;
                        res_status = rba_pkg::STAT_OK;
                    end
                end
                ref_wdata = new_cnt;
                res_count = new_cnt;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_first      <= 32'd1;
            r_zcount     <= 32'd4096;
            r_log        <= '0;
            r_free       <= FCW'(MAP_BITS - 1);
            r_out_valid  <= 1'b0;
            r_ptr        <= '0;
            r_issue_done <= 1'b0;
            r_chk        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rba_pkg::CFG_FIRST: r_first  <= i_cfg_wdata;
                    rba_pkg::CFG_COUNT: r_zcount <= i_cfg_wdata;
                    rba_pkg::CFG_LOG:   r_log    <= i_cfg_wdata[3:0];
                    default: begin
                    end
                endcase
            end
            if (free_dec) begin
                r_free <= r_free - FCW'(1);
            end else if (free_inc) begin
                r_free <= r_free + FCW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // Word reads are issued one per cycle; each is checked in the cycle after it is issued.
            if (in_acc) begin
                r_ptr        <= '0;
                r_issue_done <= 1'b0;
                r_chk        <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_chk <= !r_issue_done;
                if (!r_issue_done) begin
                    if (r_ptr == LAST_WORD) begin
                        r_issue_done <= 1'b1;
                    end else begin
                        r_ptr <= r_ptr + WAW'(1);
                    end
                end
            end
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_in_data.operation;
            r_zone <= i_in_data.zone_id;
        end
        if (r_state == S_SCAN) begin
            r_chk_addr <= r_ptr;
            if (r_chk) begin
                r_word  <= map_rdata;
                r_waddr <= r_chk_addr;
            end
        end
        if (r_state == S_PICK) begin
            r_idx <= {r_waddr, rba_pkg::first_zero(r_word)};
        end
        if (r_state == S_ALO) begin
            r_zone <= alu_sum;
        end
        if (r_state == S_AHI) begin
            r_fail <= !alu_carry;
        end
        if (r_state == S_RLO) begin
            r_d    <= alu_sum;
            r_fail <= !alu_carry;
        end
        if (r_state == S_RHI) begin
            r_fail <= r_fail | alu_carry;
        end
        if (r_state == S_RIDX) begin
            r_idx <= alu_sum[IW-1:0];
        end
        if (r_state == S_RCALC) begin
            r_count_rd <= ref_rdata;
            r_word     <= map_rdata;
        end
        if (res_load) begin
            r_res_status <= res_status;
            r_res_zone   <= res_zone;
            r_res_count  <= res_count;
        end
        if (out_load) begin
            r_out.status      <= r_res_status;
            r_out.zone        <= r_res_zone;
            r_out.ref_count   <= r_res_count;
            r_out.free_blocks <= free_shift[27:0];
        end
    end

`ifndef ASSERT_OFF
    // The free count can never exceed the number of usable map entries.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FCW'(MAP_BITS - 1))
        else $error("free counter above map size");

    // A transfer in takes the sequencer out of idle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after a transfer");

    // A finished item reaches the output register and the sequencer returns to idle.
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not registered on completion");

    // A full map reports no zone and no count.
    a_nospace_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == rba_pkg::STAT_NOSPACE) |->
        (r_out.zone == '0 && r_out.ref_count == '0))
        else $error("no-space result carries a zone or a count");
`endif

endmodule

/* src/rba_ram.sv */
module rba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/rba_alu.sv */
module rba_alu (
    input  logic              i_clk,
    input  rba_pkg::t_alu_ctl i_ctl,
    input  rba_pkg::t_word    i_a,
    input  rba_pkg::t_word    i_b,
    output rba_pkg::t_word    o_sum,
    output logic              o_carry
);

    // a + b + cin, or a + ~b + cin; a subtract leaves carry set when a >= b.
    logic [32:0]    n_res;
    rba_pkg::t_word r_sum;
    logic           r_carry;

    assign n_res = {1'b0, i_a} + {1'b0, (i_ctl.inv ? ~i_b : i_b)} + 33'(i_ctl.cin);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_sum   <= n_res[31:0];
            r_carry <= n_res[32];
        end
    end

    assign o_sum   = r_sum;
    assign o_carry = r_carry;

endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // The predictor keeps its own copy of a 4096-entry busy map, which matches the
    // default size of the block's map.
    localparam int MAP_SIZE     = 4096;
    // The limit lies above the longest allocate and the clearing pass after reset,
    // so reaching it with no transfer on either side means a hang.
    localparam int IDLE_LIMIT   = 20000;
    // Cycles allowed after the last result, to catch any stray result.
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_LINES = 40;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    rba_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    rba_pkg::t_out_item out_data;
    logic               cfg_we    = 1'b0;
    logic [1:0]         cfg_index = rba_pkg::CFG_FIRST;
    logic [31:0]        cfg_wdata = '0;

    // The predictor's view of the allocator: busy map, reference counts, the
    // number of clear bits, and the three registers.
    logic        zone_busy [MAP_SIZE];
    logic [31:0] zone_refs [MAP_SIZE];
    int unsigned clear_bits;
    logic [31:0] first_zone;
    logic [31:0] zone_limit;
    logic [3:0]  block_shift;
    // The highest map index ever marked busy. Random releases and added
    // references aim at indexes up to just above it, so that most of them touch live zones.
    int unsigned top_index;

    // Results owed by the block, oldest first.
    rba_pkg::t_out_item pending_results [$];
    int unsigned error_count  = 0;
    int unsigned results_seen = 0;
    int          idle_cycles  = 0;
    // Cycles of output stall still to apply to the next result.
    int          out_hold     = 0;
    // When set, neither side idles, which gives stretches of back-to-back transfers.
    bit          no_idle      = 1'b0;

    refcounted_block_allocator_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Number of cycles that either side waits before its next transfer.
    function automatic int draw_wait();
        if (no_idle) begin
            return 0;
        end
        return int'($urandom_range(0, 5));
    endfunction

    // Map index of a zone number, or MAP_SIZE when the zone lies outside the
    // data area or beyond the end of the map.
    function automatic int unsigned zone_index(input logic [31:0] zone);
        logic [32:0] idx;
        if (zone < first_zone || zone >= zone_limit) begin
            return MAP_SIZE;
        end
        idx = {1'b0, zone} - {1'b0, first_zone} + 33'd1;
        if (idx >= 33'(MAP_SIZE)) begin
            return MAP_SIZE;
        end
        return int'(idx);
    endfunction

    // Zone number that a map index stands for under the current layout.
    function automatic logic [31:0] index_zone(input int unsigned idx);
        return 32'(idx) + first_zone - 32'd1;
    endfunction

    // Applies one operation to the predictor's state and returns the result the
    // block must give for it.
    function automatic rba_pkg::t_out_item apply_zone_op(input rba_pkg::t_in_item op_item);
        rba_pkg::t_out_item res;
        int unsigned        idx;
        logic [31:0]        cnt;
        logic [43:0]        scaled;
        res.status    = rba_pkg::STAT_OK;
        res.zone      = op_item.zone_id;
        res.ref_count = '0;
        case (op_item.operation) inside
            rba_pkg::OP_ALLOC: begin
                // Lowest clear bit of the map.
                idx = MAP_SIZE;
                for (int k = MAP_SIZE - 1; k >= 0; k--) begin
                    if (!zone_busy[k]) begin
                        idx = k;
                    end
                end
                if (idx == MAP_SIZE) begin
                    res.status = rba_pkg::STAT_NOSPACE;
                    res.zone   = '0;
                end else begin
                    // The bit is taken even when the zone turns out to lie outside
                    // the data area.
                    zone_busy[idx] = 1'b1;
                    zone_refs[idx] = 32'd1;
                    clear_bits--;
                    res.ref_count = 32'd1;
                    if (idx > top_index) begin
                        top_index = idx;
                    end
                    res.zone = index_zone(idx);
                    if (res.zone < first_zone || res.zone >= zone_limit) begin
                        res.status = rba_pkg::STAT_OUTSIDE;
                        res.zone   = '0;
                    end
                end
            end
            rba_pkg::OP_RELEASE, rba_pkg::OP_ADDREF: begin
                idx = zone_index(op_item.zone_id);
                if (idx == MAP_SIZE) begin
                    res.status = rba_pkg::STAT_OUTSIDE;
                end else if (op_item.operation == rba_pkg::OP_RELEASE) begin
                    cnt = zone_refs[idx];
                    if (cnt == '0) begin
                        res.status = rba_pkg::STAT_UNDERFLOW;
                    end else begin
                        cnt = cnt - 32'd1;
                    end
                    zone_refs[idx] = cnt;
                    // A count at zero frees the bit; a bit that was already clear is
                    // flagged unless the underflow has been flagged first.
                    if (cnt == '0) begin
                        if (zone_busy[idx]) begin
                            zone_busy[idx] = 1'b0;
                            clear_bits++;
                        end else if (res.status == rba_pkg::STAT_OK) begin
                            res.status = rba_pkg::STAT_BITCLR;
                        end
                    end
                    res.ref_count = cnt;
                end else begin
                    cnt = zone_refs[idx];
                    if (cnt == '1) begin
                        res.status = rba_pkg::STAT_OVERFLOW;
                    end else begin
                        cnt = cnt + 32'd1;
                    end
                    zone_refs[idx] = cnt;
                    res.ref_count  = cnt;
                end
            end
            default: begin
                // The unused code changes nothing and echoes the zone.
            end
        endcase
        scaled = 44'(clear_bits) << block_shift;
        res.free_blocks = scaled[27:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= REPORT_LINES) begin
            $display("mismatch in %s at result %0d: got 0x%08h, expected 0x%08h",
                     what, results_seen, got, want);
        end
    endtask

    // Sends one operation. Valid is lowered only when a gap is drawn, so that a
    // run of transfers with no gap keeps it high and simply changes the payload.
    // The prediction is made at the edge where the transfer is accepted.
    task automatic send_zone_op(input logic [1:0] op, input logic [31:0] zone);
        rba_pkg::t_in_item op_item;
        int                gap;
        op_item.operation = op;
        op_item.zone_id   = zone;
        gap = draw_wait();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= op_item;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(apply_zone_op(op_item));
    endtask

    // Drops valid and waits until every owed result has come back. As each item
    // gives exactly one result, the block is idle from that point on.
    task automatic wait_until_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rba_pkg::CFG_FIRST: first_zone  = value;
            rba_pkg::CFG_COUNT: zone_limit  = value;
            rba_pkg::CFG_LOG:   block_shift = value[3:0];
            default: begin
            end
        endcase
    endtask

    // Rewrites all three registers once the block has gone idle.
    task automatic set_zone_layout(input logic [31:0] first, input logic [31:0] count,
                                   input logic [3:0] shift);
        wait_until_idle();
        write_reg(rba_pkg::CFG_FIRST, first);
        write_reg(rba_pkg::CFG_COUNT, count);
        write_reg(rba_pkg::CFG_LOG, 32'(shift));
    endtask

    // A zone whose index lies anywhere from 1 to just above the highest index used so far.
    function automatic logic [31:0] pick_live_zone();
        int unsigned hi;
        hi = (top_index + 1 < MAP_SIZE) ? top_index + 1 : MAP_SIZE - 1;
        return index_zone($urandom_range(1, hi));
    endfunction

    // Zones that sit on or next to the edges of the data area and of the map, or a random zone.
    function automatic logic [31:0] pick_edge_zone();
        case ($urandom_range(0, 6))
            0: return first_zone - 32'd1;
            1: return first_zone;
            2: return zone_limit - 32'd1;
            3: return zone_limit;
            4: return index_zone(MAP_SIZE - 1);
            5: return index_zone(MAP_SIZE);
            default: return $urandom;
        endcase
    endfunction

    // Under the default layout: allocate, add a reference, release it again down
    // past zero, release a zone that only ever had a reference added, and touch
    // zones on both sides of the data area, and send the unused operation code.
    task automatic test_basic_ops();
        send_zone_op(rba_pkg::OP_ALLOC, 32'h0000_0000);
        send_zone_op(rba_pkg::OP_ALLOC, 32'hFFFF_FFFF);
        send_zone_op(rba_pkg::OP_ALLOC, $urandom);
        send_zone_op(rba_pkg::OP_ADDREF, 32'd2);
        send_zone_op(rba_pkg::OP_RELEASE, 32'd2);
        send_zone_op(rba_pkg::OP_RELEASE, 32'd2);
        // The count is already zero here, so this one underflows.
        send_zone_op(rba_pkg::OP_RELEASE, 32'd2);
        // A reference added to a free zone and then released finds its bit clear.
        send_zone_op(rba_pkg::OP_ADDREF, 32'd7);
        send_zone_op(rba_pkg::OP_RELEASE, 32'd7);
        send_zone_op(rba_pkg::OP_RELEASE, 32'd0);
        send_zone_op(rba_pkg::OP_ADDREF, 32'd4096);
        send_zone_op(rba_pkg::OP_RELEASE, 32'd4095);
        send_zone_op(rba_pkg::OP_ADDREF, 32'hFFFF_FFFF);
        send_zone_op(rba_pkg::OP_NONE, 32'hA5A5_A5A5);
        // The zone freed above is handed out again.
        send_zone_op(rba_pkg::OP_ALLOC, 32'h5A5A_5A5A);
    endtask

    // The register extremes: zone numbers that wrap round, an empty data area,
    // the largest shift, and a zone just past the end of the map.
    task automatic test_layout_extremes();
        set_zone_layout(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        send_zone_op(rba_pkg::OP_ALLOC, 32'h0000_0000);
        send_zone_op(rba_pkg::OP_RELEASE, 32'hFFFF_FFFF);
        send_zone_op(rba_pkg::OP_ADDREF, 32'h1234_5678);
        set_zone_layout(32'd1, 32'd1, 4'd0);
        send_zone_op(rba_pkg::OP_ALLOC, 32'h0000_0000);
        set_zone_layout(32'h7FFF_F000, 32'h8000_0000, 4'd9);
        send_zone_op(rba_pkg::OP_ADDREF, 32'h7FFF_FFFF);
        send_zone_op(rba_pkg::OP_RELEASE, 32'h7FFF_FFFE);
        send_zone_op(rba_pkg::OP_RELEASE, 32'h7FFF_EFFF);
    endtask

    // Mostly well-formed traffic on live zones, with a share of noise: zones on
    // the edges, random zones and the unused operation code.
    task automatic run_zone_traffic(input int items);
        int unsigned roll;
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                send_zone_op(rba_pkg::OP_ALLOC, $urandom);
            end else if (roll < 65) begin
                send_zone_op(rba_pkg::OP_RELEASE, pick_live_zone());
            end else if (roll < 82) begin
                send_zone_op(rba_pkg::OP_ADDREF, pick_live_zone());
            end else begin
                send_zone_op(2'($urandom_range(0, 3)), pick_edge_zone());
            end
        end
    endtask

    task automatic test_random_layouts();
        set_zone_layout(32'd1, 32'd4096, 4'd0);
        run_zone_traffic(120);
        set_zone_layout(32'd1000, 32'd3000, 4'd3);
        run_zone_traffic(120);
        set_zone_layout(32'hFFFF_F000, 32'hFFFF_FFFF, 4'd15);
        run_zone_traffic(120);
        // Only the first few dozen indexes map into this data area.
        set_zone_layout(32'd5, 32'd40, 4'd7);
        run_zone_traffic(120);
        set_zone_layout(32'h4000_0000, 32'h4000_0800, 4'd12);
        run_zone_traffic(120);
    endtask

    // Traffic with neither side idling, so that each transfer follows the last
    // as closely as the block allows.
    task automatic test_back_to_back();
        set_zone_layout(32'd1, 32'hFFFF_FFFF, 4'd15);
        no_idle = 1'b1;
        run_zone_traffic(30);
        no_idle = 1'b0;
    endtask

    // Each accepted result is checked against the oldest prediction, and the
    // output stall for the next result is drawn.
    always @(posedge clk) begin
        rba_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            out_hold = draw_wait();
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with none owed (zone)", out_data.zone, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status) begin
                    report_mismatch("status", 32'(out_data.status), 32'(want.status));
                end
                if (out_data.zone !== want.zone) begin
                    report_mismatch("zone", out_data.zone, want.zone);
                end
                if (out_data.ref_count !== want.ref_count) begin
                    report_mismatch("ref_count", out_data.ref_count, want.ref_count);
                end
                if (out_data.free_blocks !== want.free_blocks) begin
                    report_mismatch("free_blocks", 32'(out_data.free_blocks),
                                    32'(want.free_blocks));
                end
            end
        end
    end

    // The output stall is held for the drawn number of cycles in which a result
    // is actually waiting, so that it always bites.
    always @(negedge clk) begin
        out_stall <= (out_hold != 0);
        if (out_valid && out_hold != 0) begin
            out_hold--;
        end
    end

    // Ends the run if no transfer has happened on either side for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[refcounted_block_allocator_top] ERROR");
            $finish;
        end
    end

    initial begin
        // The predictor starts from the reset state: bit 0 taken, all counts
        // zero, and the default layout.
        for (int k = 0; k < MAP_SIZE; k++) begin
            zone_busy[k] = 1'b0;
            zone_refs[k] = '0;
        end
        zone_busy[0] = 1'b1;
        clear_bits   = MAP_SIZE - 1;
        first_zone   = 32'd1;
        zone_limit   = 32'd4096;
        block_shift  = 4'd0;
        top_index    = 0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_layout_extremes();
        test_random_layouts();
        test_back_to_back();

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("[refcounted_block_allocator_top] OK");
        end else begin
            $display("[refcounted_block_allocator_top] ERROR");
        end
        $finish;
    end

endmodule
